// ===== sv/keyframe_linear_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// Keyframe linear interpolator assertion macros
// Shared concurrent assertion forms for the interpolator checker.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kli_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Sizes, field widths and function codes shared by the interpolator files.
// ----------------------------------------------------------------------------
package kli_pkg;

  localparam int MAX_KEYFRAMES = 16;
  localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);
  localparam int IDX_W         = $clog2(MAX_KEYFRAMES);

  localparam int TIME_W        = 16;
  localparam int ANGLE_W       = 16;
  localparam int NUM_ANGLES    = 8;
  localparam int ROW_W         = ANGLE_W * NUM_ANGLES;
  localparam int LANE_W        = $clog2(NUM_ANGLES + 1);
  localparam int LANE_IDX_W    = $clog2(NUM_ANGLES);

  localparam int FRAC_W        = 16;
  localparam int DIV_CNT_W     = $clog2(FRAC_W);
  localparam int DIFF_W        = ANGLE_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;

  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_APPEND = 1'b1;

endpackage

// ===== sv/keyframe_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Stores keyframes of eight joint angles and interpolates a pose at a time.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// request   start, busy            in_func, in_time_value, in_leg_*, in_knee_*
// result    out_strobe             out_ok, out_pose_*
//
// An append, or a query with fewer than two keyframes, gives its result in the next
// cycle. A query keeps busy high through N time memory reads, N being the keyframe
// count, and one span pick; if a span holds its time, busy stays high on through a
// 16-step serial divider and nine steps of one multiplier shared by the angles.
// Reset clears the keyframe count and the control state; the keyframe memories are not cleared.
// Results cannot be stalled and show for exactly one cycle.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator
  import kli_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [TIME_W-1:0]         in_time_value,
  input  logic signed [ANGLE_W-1:0] in_leg_left_x,
  input  logic signed [ANGLE_W-1:0] in_leg_left_y,
  input  logic signed [ANGLE_W-1:0] in_leg_right_x,
  input  logic signed [ANGLE_W-1:0] in_leg_right_y,
  input  logic signed [ANGLE_W-1:0] in_knee_left_x,
  input  logic signed [ANGLE_W-1:0] in_knee_left_y,
  input  logic signed [ANGLE_W-1:0] in_knee_right_x,
  input  logic signed [ANGLE_W-1:0] in_knee_right_y,
  output logic                      out_strobe,
  output logic                      out_ok,
  output logic signed [ANGLE_W-1:0] out_pose_leg_left_x,
  output logic signed [ANGLE_W-1:0] out_pose_leg_left_y,
  output logic signed [ANGLE_W-1:0] out_pose_leg_right_x,
  output logic signed [ANGLE_W-1:0] out_pose_leg_right_y,
  output logic signed [ANGLE_W-1:0] out_pose_knee_left_x,
  output logic signed [ANGLE_W-1:0] out_pose_knee_left_y,
  output logic signed [ANGLE_W-1:0] out_pose_knee_right_x,
  output logic signed [ANGLE_W-1:0] out_pose_knee_right_y
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_SCAN     = 5'b00010,
    ST_SCAN_END = 5'b00100,
    ST_DIV      = 5'b01000,
    ST_LERP     = 5'b10000
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           key_count_r;
  logic [TIME_W-1:0]          q_r;
  logic [IDX_W-1:0]           scan_idx_r;
  logic                       rd_vld_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic [TIME_W-1:0]          time_rd_r;
  logic [TIME_W-1:0]          prev_t_r;
  logic                       found_r;
  logic                       found_nxt;
  logic [IDX_W-1:0]           best_r;
  logic [IDX_W-1:0]           best_nxt;
  logic [TIME_W-1:0]          t0_r;
  logic [TIME_W-1:0]          t0_nxt;
  logic [TIME_W-1:0]          t1_r;
  logic [TIME_W-1:0]          t1_nxt;
  logic [TIME_W-1:0]          rem_r;
  logic [FRAC_W-1:0]          quo_r;
  logic [TIME_W-1:0]          span_r;
  logic                       sat_r;
  logic                       zero_r;
  logic [DIV_CNT_W-1:0]       div_cnt_r;
  logic [ROW_W-1:0]           ang_rd_r;
  logic [ROW_W-1:0]           a_r;
  logic [ROW_W-1:0]           b_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [LANE_W-1:0]          lane_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ANGLE_W-1:0]  prod_a_r;
  logic                       out_strobe_r;
  logic                       out_ok_r;
  logic signed [ANGLE_W-1:0]  out_pose_r [NUM_ANGLES];

  logic [TIME_W-1:0]          time_mem [MAX_KEYFRAMES];
  logic [ROW_W-1:0]           ang_mem  [MAX_KEYFRAMES];

  logic                       accept;
  logic                       table_full;
  logic                       mem_we;
  logic [ROW_W-1:0]           wr_row;
  logic [IDX_W-1:0]           ang_addr;
  logic [CNT_W-1:0]           cnt_m1;
  logic [IDX_W-1:0]           last_idx;
  logic                       cur_match;
  logic [TIME_W:0]            rem2;
  logic [TIME_W:0]            rem_sub;
  logic                       sub_ok;
  logic [TIME_W-1:0]          rem_step;
  logic [FRAC_W-1:0]          quo_step;
  logic [FRAC_W-1:0]          frac_div;
  logic [LANE_IDX_W-1:0]      lane_idx;
  logic [LANE_W-1:0]          lane_m1;
  logic [ANGLE_W-1:0]         a_lane;
  logic [ANGLE_W-1:0]         b_lane;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-FRAC_W-1:0] lerp_sum;

  assign accept     = start && !busy;
  assign busy       = (state_r != ST_IDLE);
  assign table_full = (key_count_r == CNT_W'(MAX_KEYFRAMES));
  assign mem_we     = accept && (in_func == FUNC_APPEND) && !table_full;
  assign wr_row     = {in_knee_right_y, in_knee_right_x, in_knee_left_y, in_knee_left_x,
                       in_leg_right_y, in_leg_right_x, in_leg_left_y, in_leg_left_x};
  assign ang_addr   = (div_cnt_r == '0) ? best_r : best_r + 1'b1;
  assign cnt_m1     = key_count_r - 1'b1;
  assign last_idx   = cnt_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[key_count_r[IDX_W-1:0]] <= in_time_value;
      ang_mem[key_count_r[IDX_W-1:0]]  <= wr_row;
    end
    time_rd_r <= time_mem[scan_idx_r];
    ang_rd_r  <= ang_mem[ang_addr];
  end

  always_comb begin
    cur_match = rd_vld_r && (rd_idx_r != '0) && (prev_t_r <= q_r) && (time_rd_r >= q_r);
    found_nxt = found_r || cur_match;
    best_nxt  = cur_match ? rd_idx_r - 1'b1 : best_r;
    t0_nxt    = cur_match ? prev_t_r : t0_r;
    t1_nxt    = cur_match ? time_rd_r : t1_r;
  end

  always_comb begin
    rem2     = {rem_r, 1'b0};
    rem_sub  = rem2 - {1'b0, span_r};
    sub_ok   = (rem2 >= {1'b0, span_r});
    rem_step = sub_ok ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
    quo_step = {quo_r[FRAC_W-2:0], sub_ok};
    if (zero_r) begin
      frac_div = '0;
    end else if (sat_r) begin
      frac_div = '1;
    end else begin
      frac_div = quo_step;
    end
  end

  always_comb begin
    lane_idx = lane_r[LANE_IDX_W-1:0];
    lane_m1  = lane_r - 1'b1;
    a_lane   = a_r[lane_idx*ANGLE_W +: ANGLE_W];
    b_lane   = b_r[lane_idx*ANGLE_W +: ANGLE_W];
    diff     = $signed({b_lane[ANGLE_W-1], b_lane}) - $signed({a_lane[ANGLE_W-1], a_lane});
    prod_nxt = $signed({1'b0, frac_r}) * diff;
    lerp_sum = $signed(prod_r[PROD_W-1:FRAC_W])
             + $signed({{(PROD_W-FRAC_W-ANGLE_W){prod_a_r[ANGLE_W-1]}}, prod_a_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_count_r  <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            if (in_func == FUNC_APPEND) begin
              out_strobe_r <= 1'b1;
              out_ok_r     <= !table_full;
              for (int i = 0; i < NUM_ANGLES; i++) out_pose_r[i] <= '0;
              if (!table_full) key_count_r <= key_count_r + 1'b1;
            end else if (key_count_r < CNT_W'(2)) begin
              out_strobe_r <= 1'b1;
              out_ok_r     <= 1'b0;
              for (int i = 0; i < NUM_ANGLES; i++) out_pose_r[i] <= '0;
            end else begin
              state_r    <= ST_SCAN;
              q_r        <= in_time_value;
              scan_idx_r <= '0;
              rd_vld_r   <= 1'b0;
              found_r    <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          rd_vld_r <= 1'b1;
          rd_idx_r <= scan_idx_r;
          found_r  <= found_nxt;
          best_r   <= best_nxt;
          t0_r     <= t0_nxt;
          t1_r     <= t1_nxt;
          if (rd_vld_r) prev_t_r <= time_rd_r;
          if (scan_idx_r == last_idx) begin
            state_r <= ST_SCAN_END;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        ST_SCAN_END: begin
          rd_vld_r <= 1'b0;
          best_r   <= best_nxt;
          if (found_nxt) begin
            state_r   <= ST_DIV;
            rem_r     <= q_r - t0_nxt;
            span_r    <= t1_nxt - t0_nxt;
            sat_r     <= (q_r == t1_nxt);
            zero_r    <= (t0_nxt == t1_nxt);
            quo_r     <= '0;
            div_cnt_r <= '0;
          end else begin
            state_r      <= ST_IDLE;
            out_strobe_r <= 1'b1;
            out_ok_r     <= 1'b0;
            for (int i = 0; i < NUM_ANGLES; i++) out_pose_r[i] <= '0;
          end
        end
        ST_DIV: begin
          rem_r     <= rem_step;
          quo_r     <= quo_step;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(1)) a_r <= ang_rd_r;
          if (div_cnt_r == DIV_CNT_W'(2)) b_r <= ang_rd_r;
          if (div_cnt_r == DIV_CNT_W'(FRAC_W - 1)) begin
            frac_r  <= frac_div;
            lane_r  <= '0;
            state_r <= ST_LERP;
          end
        end
        ST_LERP: begin
          lane_r <= lane_r + 1'b1;
          if (lane_r != LANE_W'(NUM_ANGLES)) begin
            prod_r   <= prod_nxt;
            prod_a_r <= a_lane;
          end
          if (lane_r != '0) begin
            out_pose_r[lane_m1[LANE_IDX_W-1:0]] <= lerp_sum[ANGLE_W-1:0];
          end
          if (lane_r == LANE_W'(NUM_ANGLES)) begin
            state_r      <= ST_IDLE;
            out_strobe_r <= 1'b1;
            out_ok_r     <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe            = out_strobe_r;
  assign out_ok                = out_ok_r;
  assign out_pose_leg_left_x   = out_pose_r[0];
  assign out_pose_leg_left_y   = out_pose_r[1];
  assign out_pose_leg_right_x  = out_pose_r[2];
  assign out_pose_leg_right_y  = out_pose_r[3];
  assign out_pose_knee_left_x  = out_pose_r[4];
  assign out_pose_knee_left_y  = out_pose_r[5];
  assign out_pose_knee_right_x = out_pose_r[6];
  assign out_pose_knee_right_y = out_pose_r[7];

endmodule

// ===== sv/kli_checker.sv =====
// ----------------------------------------------------------------------------
// Keyframe linear interpolator checker
// Port-level assertions on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_macros.svh"

module kli_port_checker
  import kli_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_func,
  input logic                      out_strobe,
  input logic                      out_ok,
  input logic signed [ANGLE_W-1:0] out_pose_leg_left_x,
  input logic signed [ANGLE_W-1:0] out_pose_leg_left_y,
  input logic signed [ANGLE_W-1:0] out_pose_leg_right_x,
  input logic signed [ANGLE_W-1:0] out_pose_leg_right_y,
  input logic signed [ANGLE_W-1:0] out_pose_knee_left_x,
  input logic signed [ANGLE_W-1:0] out_pose_knee_left_y,
  input logic signed [ANGLE_W-1:0] out_pose_knee_right_x,
  input logic signed [ANGLE_W-1:0] out_pose_knee_right_y
);

  logic pose_zero;
  logic req_append;
  logic req_query;
  logic append_done;
  logic fail_result;

  assign pose_zero = (out_pose_leg_left_x == '0) && (out_pose_leg_left_y == '0)
                  && (out_pose_leg_right_x == '0) && (out_pose_leg_right_y == '0)
                  && (out_pose_knee_left_x == '0) && (out_pose_knee_left_y == '0)
                  && (out_pose_knee_right_x == '0) && (out_pose_knee_right_y == '0);

  assign req_append  = start && !busy && (in_func == FUNC_APPEND);
  assign req_query   = start && !busy && (in_func == FUNC_QUERY);
  assign append_done = out_strobe && !busy && pose_zero;
  assign fail_result = out_strobe && !out_ok;

  `KLI_ASSERT_NXT(a_append_result, clk, rst_n, req_append, append_done, "append result late")
  `KLI_ASSERT_NXT(a_query_start, clk, rst_n, req_query, busy || out_strobe, "query not started")
  `KLI_ASSERT_IMP(a_fail_zero, clk, rst_n, fail_result, pose_zero, "nonzero pose on failure")
  `KLI_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result strobe while busy")
  `KLI_ASSERT_IMP(a_done_strobe, clk, rst_n, $fell(busy), out_strobe, "no result after busy")

endmodule

bind keyframe_linear_interpolator kli_port_checker u_kli_port_checker (.*);

// ===== verif/kli_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyframe interpolator checker
// Watches the request and result channels of the keyframe interpolator,
// keeps its own keyframe table, predicts each pose and compares the results
// in order against the predictions.
// ----------------------------------------------------------------------------
module kli_checker
  import kli_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_func,
  input  logic [TIME_W-1:0]                    in_time_value,
  input  logic [NUM_ANGLES-1:0][ANGLE_W-1:0]   in_angles,
  input  logic                                 out_strobe,
  input  logic                                 out_ok,
  input  logic [NUM_ANGLES-1:0][ANGLE_W-1:0]   out_pose,
  output int                                   failures,
  output int                                   outstanding
);

  typedef logic [NUM_ANGLES-1:0][ANGLE_W-1:0] angle_set_t;

  typedef struct packed {
    logic       ok;
    angle_set_t ang;
  } pose_t;

  string pose_name [NUM_ANGLES] = '{
    "pose_leg_left_x", "pose_leg_left_y", "pose_leg_right_x", "pose_leg_right_y",
    "pose_knee_left_x", "pose_knee_left_y", "pose_knee_right_x", "pose_knee_right_y"
  };

  logic [TIME_W-1:0] key_time [MAX_KEYFRAMES];
  angle_set_t        key_angle [MAX_KEYFRAMES];
  int                key_count = 0;

  pose_t pose_expected [$];
  int    mismatches = 0;
  int    pending = 0;

  assign failures    = mismatches;
  assign outstanding = pending;

  task automatic flag_mismatch(input string what);
    $display("kli_checker: %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_prediction(input pose_t p);
    pose_expected.insert(pose_expected.size(), p);
  endtask

  function automatic pose_t store_keyframe(input logic [TIME_W-1:0] t, input angle_set_t ang);
    pose_t p;
    p = '0;
    if (key_count < MAX_KEYFRAMES) begin
      key_time[key_count]  = t;
      key_angle[key_count] = ang;
      key_count++;
      p.ok = 1'b1;
    end
    return p;
  endfunction

  // The last pair whose closed span holds the time wins; a span of nonzero length
  // that ends exactly at the time gives a fraction of 0xFFFF.
  function automatic pose_t interpolate_pose(input logic [TIME_W-1:0] q);
    pose_t       p;
    bit          found;
    int          best;
    logic [31:0] span;
    logic [31:0] f;
    logic [15:0] frac;
    longint      a;
    longint      b;
    longint      r;
    p     = '0;
    found = 1'b0;
    best  = 0;
    for (int i = 0; i + 1 < key_count; i++) begin
      if (key_time[i] <= q && key_time[i+1] >= q) begin
        found = 1'b1;
        best  = i;
      end
    end
    if (found) begin
      span = 32'(key_time[best+1]) - 32'(key_time[best]);
      frac = '0;
      if (span != 0) begin
        f    = ((32'(q) - 32'(key_time[best])) << 16) / span;
        frac = (f > 32'h0000_FFFF) ? 16'hFFFF : f[15:0];
      end
      p.ok = 1'b1;
      for (int j = 0; j < NUM_ANGLES; j++) begin
        a = longint'($signed(key_angle[best][j]));
        b = longint'($signed(key_angle[best+1][j]));
        r = a + ((longint'(frac) * (b - a)) >>> 16);
        p.ang[j] = r[ANGLE_W-1:0];
      end
    end
    return p;
  endfunction

  task automatic check_result();
    pose_t want;
    if (pose_expected.size() == 0) begin
      flag_mismatch("result strobe with no request waiting");
      return;
    end
    want = pose_expected.pop_front();
    if (out_ok !== want.ok) begin
      flag_mismatch($sformatf("ok got %b want %b", out_ok, want.ok));
    end
    for (int j = 0; j < NUM_ANGLES; j++) begin
      if (out_pose[j] !== want.ang[j]) begin
        flag_mismatch($sformatf("%s got %h want %h", pose_name[j], out_pose[j], want.ang[j]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_count = 0;
    end else begin
      if (out_strobe === 1'b1) begin
        check_result();
      end
      if (start === 1'b1 && busy === 1'b0) begin
        if (in_func == FUNC_APPEND) begin
          queue_prediction(store_keyframe(in_time_value, in_angles));
        end else begin
          queue_prediction(interpolate_pose(in_time_value));
        end
      end
    end
    pending = pose_expected.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyframe interpolator testbench
// Builds a keyframe table with directed appends covering empty, single,
// zero-length, reversed and overlapping spans and a full table, then sends
// random queries aimed mostly inside stored spans, mixed with appends to the
// full table. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import kli_pkg::*;

  typedef logic [NUM_ANGLES-1:0][ANGLE_W-1:0] angle_set_t;

  localparam int RUN_LIMIT    = 500_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_CYCLES = 64;

  localparam angle_set_t ALL_MIN = {NUM_ANGLES{16'h8000}};
  localparam angle_set_t ALL_MAX = {NUM_ANGLES{16'h7FFF}};
  localparam angle_set_t MIXED_A = {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                    16'h1234, 16'hEDCB, 16'h0080, 16'hFF80};
  localparam angle_set_t MIXED_B = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                                    16'hA5A5, 16'h5A5A, 16'hFF7F, 16'h0100};

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              in_func       = FUNC_QUERY;
  logic [TIME_W-1:0] in_time_value = '0;
  angle_set_t        in_angles     = '0;

  logic                      busy;
  logic                      out_strobe;
  logic                      out_ok;
  logic signed [ANGLE_W-1:0] out_pose_leg_left_x;
  logic signed [ANGLE_W-1:0] out_pose_leg_left_y;
  logic signed [ANGLE_W-1:0] out_pose_leg_right_x;
  logic signed [ANGLE_W-1:0] out_pose_leg_right_y;
  logic signed [ANGLE_W-1:0] out_pose_knee_left_x;
  logic signed [ANGLE_W-1:0] out_pose_knee_left_y;
  logic signed [ANGLE_W-1:0] out_pose_knee_right_x;
  logic signed [ANGLE_W-1:0] out_pose_knee_right_y;

  int failures;
  int outstanding;
  int cycles = 0;

  logic [TIME_W-1:0] stored_time [MAX_KEYFRAMES];
  int                stored_count = 0;
  bit                idle_off = 1'b0;

  keyframe_linear_interpolator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_func              (in_func),
    .in_time_value        (in_time_value),
    .in_leg_left_x        (in_angles[0]),
    .in_leg_left_y        (in_angles[1]),
    .in_leg_right_x       (in_angles[2]),
    .in_leg_right_y       (in_angles[3]),
    .in_knee_left_x       (in_angles[4]),
    .in_knee_left_y       (in_angles[5]),
    .in_knee_right_x      (in_angles[6]),
    .in_knee_right_y      (in_angles[7]),
    .out_strobe           (out_strobe),
    .out_ok               (out_ok),
    .out_pose_leg_left_x  (out_pose_leg_left_x),
    .out_pose_leg_left_y  (out_pose_leg_left_y),
    .out_pose_leg_right_x (out_pose_leg_right_x),
    .out_pose_leg_right_y (out_pose_leg_right_y),
    .out_pose_knee_left_x (out_pose_knee_left_x),
    .out_pose_knee_left_y (out_pose_knee_left_y),
    .out_pose_knee_right_x(out_pose_knee_right_x),
    .out_pose_knee_right_y(out_pose_knee_right_y)
  );

  kli_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_time_value(in_time_value),
    .in_angles    (in_angles),
    .out_strobe   (out_strobe),
    .out_ok       (out_ok),
    .out_pose     ({out_pose_knee_right_y, out_pose_knee_right_x,
                    out_pose_knee_left_y, out_pose_knee_left_x,
                    out_pose_leg_right_y, out_pose_leg_right_x,
                    out_pose_leg_left_y, out_pose_leg_left_x}),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin : watchdog
    while (cycles < RUN_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  // Start stays high from one request to the next when there is no gap, so
  // it is never lowered and raised in the same time step.
  task automatic issue_request(input logic func, input logic [TIME_W-1:0] tval,
                               input angle_set_t ang);
    int gap;
    gap = idle_off ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= func;
    in_time_value <= tval;
    in_angles     <= ang;
    do @(posedge clk); while (busy !== 1'b0);
    if (func == FUNC_APPEND && stored_count < MAX_KEYFRAMES) begin
      stored_time[stored_count] = tval;
      stored_count++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic angle_set_t random_angles();
    angle_set_t a;
    for (int j = 0; j < NUM_ANGLES; j++) begin
      case ($urandom_range(0, 7))
        0:       a[j] = 16'h8000;
        1:       a[j] = 16'h7FFF;
        default: a[j] = 16'($urandom());
      endcase
    end
    return a;
  endfunction

  function automatic logic [TIME_W-1:0] query_time();
    int pick;
    int i;
    pick = $urandom_range(0, 9);
    if (stored_count >= 2 && pick < 6) begin
      i = $urandom_range(0, stored_count - 2);
      return TIME_W'($urandom_range(stored_time[i], stored_time[i+1]));
    end
    if (stored_count >= 1 && pick < 8) begin
      return stored_time[$urandom_range(0, stored_count - 1)];
    end
    return TIME_W'($urandom());
  endfunction

  function automatic logic [TIME_W-1:0] next_key_time();
    int t;
    if (stored_count == MAX_KEYFRAMES - 1) begin
      return 16'hFFFF;
    end
    if ($urandom_range(0, 3) == 0) begin
      return TIME_W'($urandom());
    end
    t = stored_time[stored_count-1] + $urandom_range(32, 6144);
    return (t > 16'hFFFE) ? 16'hFFFE : TIME_W'(t);
  endfunction

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_request(FUNC_QUERY, 16'h0000, random_angles());
    issue_request(FUNC_APPEND, 16'h0100, ALL_MIN);
    issue_request(FUNC_QUERY, 16'h0100, random_angles());
    issue_request(FUNC_APPEND, 16'h0100, ALL_MAX);
    issue_request(FUNC_QUERY, 16'h0100, random_angles());
    issue_request(FUNC_APPEND, 16'h0300, ALL_MIN);
    issue_request(FUNC_QUERY, 16'h0200, random_angles());
    issue_request(FUNC_QUERY, 16'h0300, random_angles());
    issue_request(FUNC_QUERY, 16'h0100, random_angles());
    issue_request(FUNC_QUERY, 16'hFFFF, random_angles());
    issue_request(FUNC_APPEND, 16'h0200, MIXED_A);
    issue_request(FUNC_QUERY, 16'h0250, random_angles());
    issue_request(FUNC_APPEND, 16'h0400, MIXED_B);
    issue_request(FUNC_QUERY, 16'h0280, random_angles());
    while (stored_count < MAX_KEYFRAMES) begin
      issue_request(FUNC_APPEND, next_key_time(), random_angles());
    end
    issue_request(FUNC_APPEND, 16'h0800, random_angles());
    issue_request(FUNC_QUERY, 16'hFFFF, random_angles());
    drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        idle_off = ($urandom_range(0, 3) == 0);
      end
      if (i % 500 == 499) begin
        drain();
      end
      if ($urandom_range(0, 9) == 0) begin
        issue_request(FUNC_APPEND, TIME_W'($urandom()), random_angles());
      end else begin
        issue_request(FUNC_QUERY, query_time(), random_angles());
      end
    end

    drain();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/kli_pkg.sv
sv/keyframe_linear_interpolator.sv
sv/kli_checker.sv
verif/kli_checker.sv
verif/tb_top.sv
